>>> sv/lzd_pkg.sv
// ---------------------------------------------------------------------------
// lzd_pkg
// shared constants, codes and types of the lz stream decompressor
// ---------------------------------------------------------------------------
package lzd_pkg;

	localparam int unsigned HIST_DEPTH = 32768;
	localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
	localparam int unsigned MAX_LEN    = 512;
	localparam int unsigned LEN_MIN    = 3;
	localparam int unsigned OFFSET_MIN = 1;
	localparam int unsigned HIGH_SAT   = 32'h007F_FFFF;
	localparam int unsigned UNARY_SAT  = 1023;
	localparam int unsigned COPY_W     = $clog2(MAX_LEN + 1);

	// parse phase codes
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_PLAIN  = 3'd1;
	localparam logic [2:0] PH_LZ     = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_ERROR  = 3'd4;

	// status codes
	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_BADTYPE = 3'd1;
	localparam logic [2:0] STS_TRUNC   = 3'd2;
	localparam logic [2:0] STS_OVER    = 3'd3;
	localparam logic [2:0] STS_FAR     = 3'd4;
	localparam logic [2:0] STS_LONG    = 3'd5;

	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
		logic        done;
		logic [2:0]  status;
	} res_t;

endpackage

>>> sv/lzd_ram.sv
// ---------------------------------------------------------------------------
// lzd_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module lzd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/lzd_out_reg.sv
// ---------------------------------------------------------------------------
// lzd_out_reg
// output register stage of the result stream
// ---------------------------------------------------------------------------
module lzd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  lzd_pkg::res_t res,
	output logic          res_ready,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [71:0]   m_axis_tdata,
	output logic          m_axis_tlast,
	output logic [3:0]    m_axis_tuser
);

	logic          valid_q;
	lzd_pkg::res_t res_q;

	assign res_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {4'b0, res_q.count, res_q.bytes};
	assign m_axis_tlast  = res_q.last;
	assign m_axis_tuser  = {res_q.status, res_q.done};

endmodule

>>> sv/lzd_core.sv
// ---------------------------------------------------------------------------
// lzd_core
// parse sequencer: header, flag words, token bits, factor checks and copy
// ---------------------------------------------------------------------------
module lzd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          in_eob,
	input  logic [31:0]                   capacity,
	output logic                          res_valid,
	output lzd_pkg::res_t                 res,
	input  logic                          res_ready,
	output logic                          ram_we,
	output logic [lzd_pkg::HIST_AW-1:0]   ram_waddr,
	output logic [7:0]                    ram_wdata,
	output logic [lzd_pkg::HIST_AW-1:0]   ram_raddr,
	input  logic [7:0]                    ram_rdata
);

	localparam logic [2:0] C_IDLE    = 3'd0;
	localparam logic [2:0] C_RUN     = 3'd1;
	localparam logic [2:0] C_CHECK   = 3'd2;
	localparam logic [2:0] C_COPY_RD = 3'd3;
	localparam logic [2:0] C_COPY_WR = 3'd4;
	localparam logic [2:0] C_FINAL   = 3'd5;

	localparam logic [2:0] LZ_FLAG   = 3'd0;
	localparam logic [2:0] LZ_LIT    = 3'd1;
	localparam logic [2:0] LZ_OFFLO  = 3'd2;
	localparam logic [2:0] LZ_BOUND  = 3'd3;
	localparam logic [2:0] LZ_TOKBIT = 3'd4;
	localparam logic [2:0] LZ_VNIB   = 3'd5;
	localparam logic [2:0] LZ_UNARY  = 3'd6;
	localparam logic [2:0] LZ_GR3    = 3'd7;

	logic [2:0]  st_q, st_d;
	logic [2:0]  phase_q, phase_d;
	logic [2:0]  lz_q, lz_d;
	logic [2:0]  resume_q, resume_d;
	logic [2:0]  err_q, err_d;
	logic [63:0] flag_q, flag_d;
	logic [6:0]  bits_q, bits_d;
	logic [31:0] hdr_q, hdr_d;
	logic [23:0] rem_q, rem_d;
	logic [31:0] dec_q, dec_d;
	logic [22:0] fa_q, fa_d;
	logic [31:0] pend_q, pend_d;
	logic [2:0]  wac_q, wac_d;
	logic [3:0]  nv_q, nv_d;
	logic [2:0]  nb_q, nb_d;
	logic [3:0]  nc_q, nc_d;
	logic        eob_q, eob_d;
	logic [63:0] word_q, word_d;
	logic [3:0]  fill_q, fill_d;
	logic [lzd_pkg::COPY_W-1:0] copy_q, copy_d;

	logic [31:0] hdr_new;
	logic [3:0]  nv_new;
	logic [3:0]  nc_new;
	logic [23:0] fa_inc;
	logic [26:0] acc_next;
	logic [32:0] end_count;
	logic [31:0] src;
	logic        bit_in;

	assign hdr_new   = hdr_q | ({24'b0, in_byte} << {wac_q[1:0], 3'b000});
	assign bit_in    = flag_q[63];
	assign nv_new    = {nv_q[2:0], bit_in};
	assign nc_new    = nc_q + 4'd1;
	assign fa_inc    = {1'b0, fa_q} + 24'd1;
	assign acc_next  = {fa_inc, nv_new[2:0]};
	assign end_count = {1'b0, dec_q} + {19'b0, {1'b0, fa_q[9:0], nv_q[2:0]} + 14'(lzd_pkg::LEN_MIN)};
	assign src       = dec_q - pend_q;

	assign in_ready  = (st_q == C_IDLE);
	assign ram_raddr = src[lzd_pkg::HIST_AW-1:0];
	assign ram_waddr = dec_q[lzd_pkg::HIST_AW-1:0];

	always_comb begin
		logic [13:0] flen;
		st_d     = st_q;
		phase_d  = phase_q;
		lz_d     = lz_q;
		resume_d = resume_q;
		err_d    = err_q;
		flag_d   = flag_q;
		bits_d   = bits_q;
		hdr_d    = hdr_q;
		rem_d    = rem_q;
		dec_d    = dec_q;
		fa_d     = fa_q;
		pend_d   = pend_q;
		wac_d    = wac_q;
		nv_d     = nv_q;
		nb_d     = nb_q;
		nc_d     = nc_q;
		eob_d    = eob_q;
		word_d   = word_q;
		fill_d   = fill_q;
		copy_d   = copy_q;
		ram_we    = 1'b0;
		ram_wdata = in_byte;
		res_valid = 1'b0;
		res       = '{bytes: word_q, count: fill_q, last: 1'b0, done: 1'b0,
			status: lzd_pkg::STS_OK};
		flen = {1'b0, fa_q[9:0], nv_q[2:0]} + 14'(lzd_pkg::LEN_MIN);

		unique case (st_q)
			C_IDLE: begin
				if (in_valid) begin
					eob_d = in_eob;
					st_d  = C_FINAL;
					case (phase_q)
						lzd_pkg::PH_HEADER: begin
							hdr_d = hdr_new;
							if (wac_q < 3'd3) begin
								wac_d = wac_q + 3'd1;
							end else begin
								wac_d = 3'd0;
								rem_d = hdr_new[23:0];
								if (hdr_new[31:24] >= 8'd2) begin
									phase_d = lzd_pkg::PH_ERROR;
									err_d   = lzd_pkg::STS_BADTYPE;
								end else if (in_eob && hdr_new[23:0] != 24'd0) begin
									phase_d = lzd_pkg::PH_ERROR;
									err_d   = lzd_pkg::STS_TRUNC;
								end else if (hdr_new[31:24] == 8'd0) begin
									if ({8'b0, hdr_new[23:0]} > capacity) begin
										phase_d = lzd_pkg::PH_ERROR;
										err_d   = lzd_pkg::STS_OVER;
									end else if (hdr_new[23:0] == 24'd0) begin
										phase_d = lzd_pkg::PH_DONE;
									end else begin
										phase_d = lzd_pkg::PH_PLAIN;
									end
								end else begin
									phase_d = lzd_pkg::PH_LZ;
									lz_d    = LZ_BOUND;
									st_d    = C_RUN;
								end
							end
						end
						lzd_pkg::PH_PLAIN: begin
							rem_d  = rem_q - 24'd1;
							dec_d  = dec_q + 32'd1;
							word_d = {56'b0, in_byte};
							fill_d = 4'd1;
							if (rem_q == 24'd1) begin
								phase_d = lzd_pkg::PH_DONE;
							end
						end
						lzd_pkg::PH_LZ: begin
							rem_d = rem_q - 24'd1;
							st_d  = C_RUN;
							case (lz_q)
								LZ_FLAG: begin
									flag_d = flag_q | ({56'b0, in_byte} << {wac_q, 3'b000});
									if (wac_q == 3'd7) begin
										wac_d  = 3'd0;
										bits_d = 7'd64;
										lz_d   = resume_q;
									end else begin
										wac_d = wac_q + 3'd1;
									end
								end
								LZ_LIT: begin
									if (dec_q >= capacity) begin
										phase_d = lzd_pkg::PH_ERROR;
										err_d   = lzd_pkg::STS_OVER;
									end else begin
										ram_we = 1'b1;
										word_d = {56'b0, in_byte};
										fill_d = 4'd1;
										dec_d  = dec_q + 32'd1;
										lz_d   = LZ_BOUND;
									end
								end
								LZ_OFFLO: begin
									pend_d = {1'b0, fa_q, in_byte} + 32'(lzd_pkg::OFFSET_MIN);
									fa_d   = 23'd0;
									lz_d   = LZ_UNARY;
								end
								default: begin
								end
							endcase
						end
						default: begin
						end
					endcase
				end
			end

			C_RUN: begin
				if (phase_q != lzd_pkg::PH_LZ) begin
					st_d = C_FINAL;
				end else if (lz_q == LZ_BOUND) begin
					if (rem_q == 24'd0) begin
						phase_d = lzd_pkg::PH_DONE;
						st_d    = C_FINAL;
					end else begin
						lz_d = LZ_TOKBIT;
					end
				end else if (lz_q == LZ_FLAG || lz_q == LZ_LIT || lz_q == LZ_OFFLO) begin
					st_d = C_FINAL;
				end else if (bits_q == 7'd0) begin
					// flag word exhausted: fetch the next one
					st_d = C_FINAL;
					if (rem_q < 24'd8) begin
						phase_d = lzd_pkg::PH_ERROR;
						err_d   = lzd_pkg::STS_TRUNC;
					end else begin
						resume_d = lz_q;
						lz_d     = LZ_FLAG;
						flag_d   = 64'd0;
						wac_d    = 3'd0;
					end
				end else begin
					flag_d = {flag_q[62:0], 1'b0};
					bits_d = bits_q - 7'd1;
					case (lz_q)
						LZ_TOKBIT: begin
							if (!bit_in) begin
								st_d = C_FINAL;
								if (rem_q == 24'd0) begin
									phase_d = lzd_pkg::PH_ERROR;
									err_d   = lzd_pkg::STS_TRUNC;
								end else begin
									lz_d = LZ_LIT;
								end
							end else begin
								lz_d = LZ_VNIB;
								fa_d = 23'd0;
								nv_d = 4'd0;
								nb_d = 3'd0;
								nc_d = 4'd0;
							end
						end
						LZ_VNIB: begin
							nv_d = nv_new;
							nb_d = nb_q + 3'd1;
							if (nb_q == 3'd3) begin
								if (nc_q == 4'd0) begin
									fa_d = {20'b0, nv_new[2:0]};
								end else if (acc_next > 27'(lzd_pkg::HIGH_SAT)) begin
									fa_d = 23'(lzd_pkg::HIGH_SAT);
								end else begin
									fa_d = acc_next[22:0];
								end
								nc_d = nc_new;
								nb_d = 3'd0;
								if (nv_new[3] || nc_new == 4'd11) begin
									st_d = C_FINAL;
									if (rem_q == 24'd0) begin
										phase_d = lzd_pkg::PH_ERROR;
										err_d   = lzd_pkg::STS_TRUNC;
									end else begin
										lz_d = LZ_OFFLO;
									end
								end else begin
									nv_d = 4'd0;
								end
							end
						end
						LZ_UNARY: begin
							if (!bit_in) begin
								if (fa_q < 23'(lzd_pkg::UNARY_SAT)) begin
									fa_d = fa_q + 23'd1;
								end
							end else begin
								lz_d = LZ_GR3;
								nv_d = 4'd0;
								nb_d = 3'd0;
							end
						end
						default: begin
							nv_d = {1'b0, nv_new[2:0]};
							nb_d = nb_q + 3'd1;
							if (nb_q == 3'd2) begin
								st_d = C_CHECK;
							end
						end
					endcase
				end
			end

			C_CHECK: begin
				if (flen > 14'(lzd_pkg::MAX_LEN)) begin
					phase_d = lzd_pkg::PH_ERROR;
					err_d   = lzd_pkg::STS_LONG;
					st_d    = C_FINAL;
				end else if (pend_q > dec_q || pend_q > 32'(lzd_pkg::HIST_DEPTH)) begin
					phase_d = lzd_pkg::PH_ERROR;
					err_d   = lzd_pkg::STS_FAR;
					st_d    = C_FINAL;
				end else if (end_count > {1'b0, capacity}) begin
					phase_d = lzd_pkg::PH_ERROR;
					err_d   = lzd_pkg::STS_OVER;
					st_d    = C_FINAL;
				end else begin
					copy_d = flen[lzd_pkg::COPY_W-1:0];
					st_d   = C_COPY_RD;
				end
			end

			C_COPY_RD: begin
				// a full word leaves only when another byte must go in
				if (fill_q == 4'd8) begin
					if (res_ready) begin
						res_valid = 1'b1;
						word_d    = 64'd0;
						fill_d    = 4'd0;
						st_d      = C_COPY_WR;
					end
				end else begin
					st_d = C_COPY_WR;
				end
			end

			C_COPY_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				word_d    = word_q | ({56'b0, ram_rdata} << {fill_q[2:0], 3'b000});
				fill_d    = fill_q + 4'd1;
				dec_d     = dec_q + 32'd1;
				copy_d    = copy_q - {{(lzd_pkg::COPY_W-1){1'b0}}, 1'b1};
				if (copy_q == {{(lzd_pkg::COPY_W-1){1'b0}}, 1'b1}) begin
					lz_d = LZ_BOUND;
					st_d = C_RUN;
				end else begin
					st_d = C_COPY_RD;
				end
			end

			C_FINAL: begin
				if (res_ready) begin
					res_valid = 1'b1;
					res.last  = 1'b1;
					if (eob_q && phase_q != lzd_pkg::PH_DONE && phase_q != lzd_pkg::PH_ERROR) begin
						phase_d    = lzd_pkg::PH_ERROR;
						err_d      = lzd_pkg::STS_TRUNC;
						res.status = lzd_pkg::STS_TRUNC;
					end else begin
						res.done   = (phase_q == lzd_pkg::PH_DONE);
						res.status = (phase_q == lzd_pkg::PH_ERROR) ? err_q : lzd_pkg::STS_OK;
					end
					word_d = 64'd0;
					fill_d = 4'd0;
					st_d   = C_IDLE;
				end
			end

			default: begin
				st_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= C_IDLE;
			phase_q  <= lzd_pkg::PH_HEADER;
			lz_q     <= LZ_BOUND;
			resume_q <= LZ_BOUND;
			err_q    <= lzd_pkg::STS_OK;
			flag_q   <= 64'd0;
			bits_q   <= 7'd0;
			hdr_q    <= 32'd0;
			rem_q    <= 24'd0;
			dec_q    <= 32'd0;
			fa_q     <= 23'd0;
			pend_q   <= 32'd0;
			wac_q    <= 3'd0;
			nv_q     <= 4'd0;
			nb_q     <= 3'd0;
			nc_q     <= 4'd0;
			eob_q    <= 1'b0;
			word_q   <= 64'd0;
			fill_q   <= 4'd0;
			copy_q   <= '0;
		end else begin
			st_q     <= st_d;
			phase_q  <= phase_d;
			lz_q     <= lz_d;
			resume_q <= resume_d;
			err_q    <= err_d;
			flag_q   <= flag_d;
			bits_q   <= bits_d;
			hdr_q    <= hdr_d;
			rem_q    <= rem_d;
			dec_q    <= dec_d;
			fa_q     <= fa_d;
			pend_q   <= pend_d;
			wac_q    <= wac_d;
			nv_q     <= nv_d;
			nb_q     <= nb_d;
			nc_q     <= nc_d;
			eob_q    <= eob_d;
			word_q   <= word_d;
			fill_q   <= fill_d;
			copy_q   <= copy_d;
		end
	end

endmodule

>>> sv/lz_stream_decompressor.sv
// ---------------------------------------------------------------------------
// lz_stream_decompressor
// header, plain pass-through and lz77 decoding, one compressed byte a word
// ---------------------------------------------------------------------------
// sequence: each word goes from the idle state to its final result; an lz word
// also passes through boundary checks, flag fetches and token bits, one check
// per factor and, per copied byte, a registered history read, then a write
// flow: one input word at a time, ready again once its last result is
// taken by the output register; a long factor holds it until its copy ends
// reset: arst_n clears parse state, capacity to all ones; history not cleared
module lz_stream_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // stream_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // out_bytes[63:0], byte_count[67:64], zero fill
	output logic        m_axis_tlast,
	output logic [3:0]  m_axis_tuser,   // stream_done[0], status[3:1]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic [31:0]                 cap_q;
	logic                        res_valid;
	logic                        res_ready;
	lzd_pkg::res_t               res;
	logic                        ram_we;
	logic [lzd_pkg::HIST_AW-1:0] ram_waddr;
	logic [lzd_pkg::HIST_AW-1:0] ram_raddr;
	logic [7:0]                  ram_wdata;
	logic [7:0]                  ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	lzd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_eob    (s_axis_tlast),
		.capacity  (cap_q),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	lzd_ram #(
		.WIDTH (8),
		.DEPTH (lzd_pkg::HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lzd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.res_ready     (res_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
